/* rtl/core/dde_pkg.sv */
// Package for the digitizer event deframer: payload structs, job record
// passed from front to back, and fixed codes. No dependencies.
package dde_pkg;

  // Stream framing
  localparam logic [31:0] HEADER_WORD = 32'hFFFF_FFFF;
  localparam logic [11:0] SPC_RESET   = 12'd1248;

  // Longest waveform per channel; sample_index is sized for it
  localparam int MAX_SAMPLES = 2048;

  // Header word positions after the header
  localparam logic [3:0] HDR_IDLE   = 4'd0;
  localparam logic [3:0] HDR_FIRST  = 4'd1;
  localparam logic [3:0] HDR_TS_LO  = 4'd1;
  localparam logic [3:0] HDR_TS_HI  = 4'd2;
  localparam logic [3:0] HDR_ICNT   = 4'd3;
  localparam logic [3:0] HDR_EVCNT  = 4'd6;
  localparam logic [3:0] HDR_LAST   = 4'd7;

  // Input op codes
  localparam logic OP_WORD = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Result kinds
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Summary status codes
  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  // Channel fed by the low half of slot 4
  localparam logic [3:0] CH_SLOT4 = 4'd8;
  localparam logic [2:0] SLOT4    = 3'd4;

  // Job queue depth between front and back
  localparam int JOB_Q_DEPTH = 4;

  // Config register index
  localparam logic REG_SPC = 1'b0;

  typedef struct packed {
    logic        op;
    logic [31:0] word;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  channel;
    logic [10:0] sample_index;
    logic [15:0] sample_value;
    logic [63:0] timestamp;
    logic [31:0] internal_count;
    logic [31:0] event_count;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_PAIR    = 2'd0,
    JOB_SINGLE  = 2'd1,
    JOB_SUMMARY = 2'd2
  } job_kind_t;

  // One job = all results caused by one input word
  typedef struct packed {
    job_kind_t   kind;
    logic [3:0]  channel;       // high-half channel of a pair, 8 for single
    logic [10:0] sample_index;
    logic [31:0] word;
    logic [63:0] timestamp;
    logic [31:0] internal_count;
    logic [31:0] event_count;
    logic [1:0]  status;
  } job_t;

endpackage

/* rtl/core/dde_front.sv */
// Front part of the deframer: classifies each accepted word, keeps the event
// state and produces one job per word that causes results. Uses dde_pkg.
module dde_front
  import dde_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_acc,
  input  in_item_t    item,
  input  logic [11:0] spc,
  output logic        job_push,
  output job_t        job
);

  localparam int CNT_W = $clog2(8 * MAX_SAMPLES) + 1;

  logic [3:0]       hdr_pos_r,   hdr_pos_nxt;
  logic [CNT_W-1:0] data_cnt_r,  data_cnt_nxt;
  logic [31:0]      ts_lo_r,     ts_lo_nxt;
  logic [63:0]      event_ts_r,  event_ts_nxt;
  logic [31:0]      icnt_r,      icnt_nxt;
  logic [31:0]      evcnt_r,     evcnt_nxt;
  logic             ec_seen_r,   ec_seen_nxt;
  logic             zero_seen_r, zero_seen_nxt;

  logic [CNT_W-1:0] n_len;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] need;
  logic [CNT_W-1:0] idx_full;
  logic [2:0]       slot;
  logic [15:0]      hi_half;
  logic [15:0]      lo_half;
  logic [1:0]       sum_status;

  // Effective length, clamped to 1..MAX_SAMPLES
  always_comb begin
    if (spc == 12'd0) begin
      n_len = CNT_W'(1);
    end else if (int'(spc) > MAX_SAMPLES) begin
      n_len = CNT_W'(MAX_SAMPLES);
    end else begin
      n_len = CNT_W'(spc);
    end
  end

  assign limit    = n_len << 3;
  assign need     = limit - CNT_W'(3);
  assign idx_full = data_cnt_r >> 3;
  assign slot     = data_cnt_r[2:0];
  assign hi_half  = item.word[31:16];
  assign lo_half  = item.word[15:0];

  // Summary status from the current event
  always_comb begin
    if (data_cnt_r < need) begin
      sum_status = ST_MISSING;
    end else if (zero_seen_r) begin
      sum_status = ST_ZERO;
    end else begin
      sum_status = ST_GOOD;
    end
  end

  // Classification and state update
  always_comb begin
    hdr_pos_nxt   = hdr_pos_r;
    data_cnt_nxt  = data_cnt_r;
    ts_lo_nxt     = ts_lo_r;
    event_ts_nxt  = event_ts_r;
    icnt_nxt      = icnt_r;
    evcnt_nxt     = evcnt_r;
    ec_seen_nxt   = ec_seen_r;
    zero_seen_nxt = zero_seen_r;

    job_push           = 1'b0;
    job.kind           = JOB_SUMMARY;
    job.channel        = 4'd0;
    job.sample_index   = 11'(idx_full);
    job.word           = item.word;
    job.timestamp      = event_ts_r;
    job.internal_count = icnt_r;
    job.event_count    = evcnt_r;
    job.status         = sum_status;

    if (item_acc) begin
      if (item.op == OP_END) begin
        // end of stream: summary always, then close the event
        job_push      = 1'b1;
        job.kind      = JOB_SUMMARY;
        data_cnt_nxt  = '0;
        zero_seen_nxt = 1'b0;
        event_ts_nxt  = '0;
        hdr_pos_nxt   = HDR_IDLE;
      end else if (item.word == HEADER_WORD) begin
        if (ec_seen_r) begin
          job_push      = 1'b1;
          job.kind      = JOB_SUMMARY;
          data_cnt_nxt  = '0;
          zero_seen_nxt = 1'b0;
          event_ts_nxt  = '0;
        end
        hdr_pos_nxt = HDR_FIRST;
      end else if (hdr_pos_r >= HDR_FIRST && hdr_pos_r <= HDR_LAST) begin
        // header words by position
        case (hdr_pos_r)
          HDR_TS_LO: ts_lo_nxt = item.word;
          HDR_TS_HI: event_ts_nxt = {item.word, ts_lo_r};
          HDR_ICNT:  icnt_nxt = item.word;
          HDR_EVCNT: begin
            evcnt_nxt   = item.word;
            ec_seen_nxt = 1'b1;
          end
          default: ;
        endcase
        hdr_pos_nxt = hdr_pos_r + 4'd1;
      end else if (data_cnt_r < limit) begin
        // data word; slots 5..7 only count
        if (slot < SLOT4) begin
          job_push    = 1'b1;
          job.kind    = JOB_PAIR;
          job.channel = {slot, 1'b1};
          if (hi_half == 16'd0 || lo_half == 16'd0) begin
            zero_seen_nxt = 1'b1;
          end
        end else if (slot == SLOT4) begin
          job_push    = 1'b1;
          job.kind    = JOB_SINGLE;
          job.channel = CH_SLOT4;
          if (lo_half == 16'd0) begin
            zero_seen_nxt = 1'b1;
          end
        end
        data_cnt_nxt = data_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r   <= HDR_IDLE;
      data_cnt_r  <= '0;
      ts_lo_r     <= '0;
      event_ts_r  <= '0;
      icnt_r      <= '0;
      evcnt_r     <= '1;
      ec_seen_r   <= 1'b0;
      zero_seen_r <= 1'b0;
    end else begin
      hdr_pos_r   <= hdr_pos_nxt;
      data_cnt_r  <= data_cnt_nxt;
      ts_lo_r     <= ts_lo_nxt;
      event_ts_r  <= event_ts_nxt;
      icnt_r      <= icnt_nxt;
      evcnt_r     <= evcnt_nxt;
      ec_seen_r   <= ec_seen_nxt;
      zero_seen_r <= zero_seen_nxt;
    end
  end

  // End of stream always closes the event
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (item_acc && item.op == OP_END) |=> (hdr_pos_r == HDR_IDLE && data_cnt_r == '0))
    else $error("end of stream did not clear the event");

  // Header position never walks past the data position
  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_pos_r <= HDR_LAST + 4'd1)
    else $error("header position out of range");

  // Event counter marks once set stay set
  a_ec_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ec_seen_r |=> ec_seen_r)
    else $error("event counter seen flag dropped");

endmodule

/* rtl/core/dde_job_queue.sv */
// Short job queue between the front and back parts of the deframer.
// Register-based ring of JOB_Q_DEPTH entries. Uses dde_pkg.
module dde_job_queue
  import dde_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output job_t rd_job,
  output logic empty
);

  localparam int PTR_W = $clog2(JOB_Q_DEPTH);
  localparam int CNT_W = $clog2(JOB_Q_DEPTH + 1);

  job_t             mem_r [JOB_Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full   = (count_r == CNT_W'(JOB_Q_DEPTH));
  assign empty  = (count_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!do_wr && do_rd) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("job written into a full queue");

  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != CNT_W'(JOB_Q_DEPTH)) |-> (PTR_W'(wr_ptr_r - rd_ptr_r) == PTR_W'(count_r)))
    else $error("queue pointers disagree with fill count");

endmodule

/* rtl/core/dde_back.sv */
// Back part of the deframer: expands queued jobs into result items, one per
// cycle while the output register is free or popped, into it. Uses dde_pkg.
module dde_back
  import dde_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_head,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic      second_half_r, second_half_nxt;
  logic      load;
  logic      job_done;
  out_item_t res;

  // Result for the current job and half
  always_comb begin
    res                = '0;
    job_done           = 1'b1;
    case (q_head.kind)
      JOB_PAIR: begin
        res.kind         = KIND_SAMPLE;
        res.sample_index = q_head.sample_index;
        if (second_half_r) begin
          res.channel      = q_head.channel - 4'd1;
          res.sample_value = q_head.word[15:0];
          res.last         = 1'b1;
        end else begin
          res.channel      = q_head.channel;
          res.sample_value = q_head.word[31:16];
          res.last         = 1'b0;
          job_done         = 1'b0;
        end
      end
      JOB_SINGLE: begin
        res.kind         = KIND_SAMPLE;
        res.channel      = q_head.channel;
        res.sample_index = q_head.sample_index;
        res.sample_value = q_head.word[15:0];
        res.last         = 1'b1;
      end
      JOB_SUMMARY: begin
        res.kind           = KIND_SUMMARY;
        res.timestamp      = q_head.timestamp;
        res.internal_count = q_head.internal_count;
        res.event_count    = q_head.event_count;
        res.status         = q_head.status;
        res.last           = 1'b1;
      end
      default: ;
    endcase
  end

  // Output register takes a new result when free or being popped
  assign load  = !out_valid_r || pop;
  assign q_pop = load && !q_empty && job_done;

  always_comb begin
    out_valid_nxt   = out_valid_r;
    second_half_nxt = second_half_r;
    if (load) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        second_half_nxt = !job_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      second_half_r <= 1'b0;
    end else begin
      out_valid_r   <= out_valid_nxt;
      second_half_r <= second_half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_item_r <= res;
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_item_r;

  // Second half pending means a pair job still heads the queue
  a_half_pair: assert property (@(posedge clk) disable iff (!rst_n)
    second_half_r |-> (!q_empty && q_head.kind == JOB_PAIR))
    else $error("second half pending without a pair job");

endmodule

/* rtl/core/digitizer_event_deframer.sv */
// Digitizer event deframer: takes raw 32-bit stream words through a queue
// style input and returns per-channel samples and event summaries.
//
// Input channel: an item (op, word) is transferred when push is high and
//   full is low. op = 0 is a stream word, op = 1 ends the stream and closes
//   the current event. One word per cycle is taken while the job queue has
//   room.
// Result channel: the oldest result sits on out_item while empty is low and
//   is transferred when pop is high. A data word in slots 0..3 gives two
//   results (high half channel first), slot 4 gives one, a header after an
//   event counter or end of stream gives a summary.
// Path: each job passes through the job queue, then the output register.
// Throughput: one word per cycle in while the queue has room; one result per
//   cycle out while pop is high, so a run of two-result words fills the queue.
// Stall: when pop stays low the output register holds, the JOB_Q_DEPTH job
//   queue fills, then full rises and input stalls; nothing is dropped.
// Reset (rst_n low, synchronous): queues empty, event state cleared,
//   event counter all ones, samples_per_channel back to 1248.
// Config: samples_per_channel at byte address 0 of the APB-style port.
// Uses dde_pkg, dde_front, dde_job_queue, dde_back.
module digitizer_event_deframer
  import dde_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  // result channel
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0] spc_r, spc_nxt;
  logic        cfg_wr;
  logic        in_acc;
  logic        job_push;
  job_t        job;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  job_t        q_head;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SPC);
  assign spc_nxt = cfg_wr ? pwdata[11:0] : spc_r;
  assign prdata = (paddr[2] == REG_SPC) ? {20'd0, spc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r <= SPC_RESET;
    end else begin
      spc_r <= spc_nxt;
    end
  end

  // Input transfer
  assign full   = q_full;
  assign in_acc = push && !q_full;

  dde_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_acc (in_acc),
    .item     (in_item),
    .spc      (spc_r),
    .job_push (job_push),
    .job      (job)
  );

  dde_job_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .wr_job (job),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_job (q_head),
    .empty  (q_empty)
  );

  dde_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule
